// ===== design/bte_pkg.sv =====
// shared types, constants and helpers for the bcd date/time to epoch converter
// no dependencies
package bte_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DecW   = 8;   // decoded byte, 0..165
  localparam int unsigned YOffW  = 7;   // years since 1970, 0..99
  localparam int unsigned DaysW  = 16;  // day count before the minus-one, below 2^16
  localparam int unsigned TodW   = 20;  // seconds within the day, below 2^20
  localparam int unsigned EpochW = 32;

  localparam logic [DecW-1:0]   YearPivot    = 8'd70;
  localparam logic [YOffW-1:0]  Y2kOffset    = 7'd30;  // 2000 - 1970
  localparam logic [YOffW-1:0]  CenturyOff   = 7'd31;  // 2001 - 1970
  localparam logic [DecW-1:0]   MonthMax     = 8'd12;
  localparam logic [16:0]       SecPerDay    = 17'd86400;
  localparam logic [11:0]       SecPerHour   = 12'd3600;
  localparam logic [5:0]        SecPerMin    = 6'd60;
  localparam logic [8:0]        DaysPerYear  = 9'd365;

  // high nibble times ten plus low nibble, non-bcd nibbles included
  function automatic logic [DecW-1:0] nib_decode(input logic [ByteW-1:0] b);
    logic [DecW-1:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // days before the first of the month, month index 0..11
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/bte_day_count.sv =====
// day count from decoded year, month and day of month
// depends on bte_pkg
module bte_day_count (
  input  logic [bte_pkg::DecW-1:0]  year_dec_i,
  input  logic [bte_pkg::DecW-1:0]  month_dec_i,
  input  logic [bte_pkg::DecW-1:0]  day_dec_i,
  output logic [bte_pkg::DaysW-1:0] days_o
);

  localparam int unsigned DaysW = bte_pkg::DaysW;

  logic [bte_pkg::YOffW-1:0] y_off;
  logic [1:0]                y_mod4;
  logic                      leap;
  logic                      cent_div;   // (year - 1901) / 100
  logic                      quad_div;   // (year - 1601) / 400
  logic [3:0]                m_idx;
  logic [bte_pkg::DaysW-1:0] yr_days;

  always_comb begin
    if (year_dec_i < bte_pkg::YearPivot) begin
      y_off = year_dec_i[bte_pkg::YOffW-1:0] + bte_pkg::Y2kOffset;
    end else begin
      y_off = year_dec_i[bte_pkg::YOffW-1:0] - bte_pkg::YearPivot[bte_pkg::YOffW-1:0];
    end
  end

  // window is 1970..2069: only 2000 is a century year, and it is a leap year
  assign y_mod4   = y_off[1:0] + 2'd2;
  assign leap     = (y_mod4 == 2'd0);
  assign cent_div = (y_off >= bte_pkg::CenturyOff);
  assign quad_div = (y_off >= bte_pkg::CenturyOff);
  assign m_idx    = month_dec_i[3:0] - 4'd1;

  assign yr_days = DaysW'({9'd0, y_off} * {7'd0, bte_pkg::DaysPerYear})
                 + DaysW'({y_off + 7'd1} >> 2)
                 - DaysW'(cent_div) + DaysW'(quad_div);

  assign days_o = yr_days
                + DaysW'(bte_pkg::cum_days(m_idx))
                + DaysW'(leap && (month_dec_i > 8'd2))
                + DaysW'(day_dec_i);

endmodule

// ===== design/bcd_datetime_to_epoch_seconds.sv =====
// top level: bcd real-time-clock date and time to seconds since 1970
// depends on bte_pkg and bte_day_count
//
// usage
//   drive the six raw bcd bytes and pulse start_i; a beat is taken at every
//   rising edge with start_i high and busy_o low. busy_o is always low, so a
//   new beat can be issued in every cycle, one conversion per clock.
//   each result beat shows on epoch_seconds_o / month_invalid_o for one
//   cycle with done_o high; the receiver must take it then, it cannot stall.
//   each beat passes through the stage 1, 2, 3 and 4 registers in turn, and
//   results leave in the order the beats came in.
//   pipeline
//     stage 1  nibble decode of all six bytes, month range check
//     stage 2  day count (year, month table, leap day, day of month) and
//              seconds within the day
//     stage 3  day count times 86400, the one wide multiplier
//     stage 4  final add with the minus-one day, wrap at 32 bits, zero on
//              a bad month
//   reset clears the valid bits only; no beat is in flight afterwards
//   a month outside 1..12 gives month_invalid_o high and epoch_seconds_o 0
module bcd_datetime_to_epoch_seconds (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  second_bcd_i,
  input  logic [7:0]  minute_bcd_i,
  input  logic [7:0]  hour_bcd_i,
  input  logic [7:0]  day_bcd_i,
  input  logic [7:0]  month_bcd_i,
  input  logic [7:0]  year_bcd_i,
  output logic        done_o,
  output logic [31:0] epoch_seconds_o,
  output logic        month_invalid_o
);

  localparam int unsigned DecW   = bte_pkg::DecW;
  localparam int unsigned DaysW  = bte_pkg::DaysW;
  localparam int unsigned TodW   = bte_pkg::TodW;
  localparam int unsigned EpochW = bte_pkg::EpochW;

  logic accept;
  assign busy_o = 1'b0;               // pipeline never holds off
  assign accept = start_i && !busy_o;

  // stage 1: nibble decode
  logic            s1_valid_q;
  logic [DecW-1:0] s1_sec_q, s1_min_q, s1_hr_q, s1_day_q, s1_mon_q, s1_yr_q;
  logic            s1_bad_q;
  logic [DecW-1:0] mon_dec;
  logic            mon_bad;

  assign mon_dec = bte_pkg::nib_decode(month_bcd_i);
  assign mon_bad = (mon_dec == 8'd0) || (mon_dec > bte_pkg::MonthMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sec_q <= bte_pkg::nib_decode(second_bcd_i);
      s1_min_q <= bte_pkg::nib_decode(minute_bcd_i);
      s1_hr_q  <= bte_pkg::nib_decode(hour_bcd_i);
      s1_day_q <= bte_pkg::nib_decode(day_bcd_i);
      s1_mon_q <= mon_dec;
      s1_yr_q  <= bte_pkg::nib_decode(year_bcd_i);
      s1_bad_q <= mon_bad;
    end
  end

  // stage 2: day count and seconds within the day
  logic             s2_valid_q;
  logic [DaysW-1:0] s2_days_q;
  logic [TodW-1:0]  s2_tod_q;
  logic             s2_bad_q;
  logic [DaysW-1:0] days_d;
  logic [TodW-1:0]  tod_d;

  bte_day_count u_day_count (
    .year_dec_i  (s1_yr_q),
    .month_dec_i (s1_mon_q),
    .day_dec_i   (s1_day_q),
    .days_o      (days_d)
  );

  assign tod_d = TodW'({12'd0, s1_hr_q} * {8'd0, bte_pkg::SecPerHour})
               + TodW'({6'd0, s1_min_q} * {8'd0, bte_pkg::SecPerMin})
               + TodW'(s1_sec_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_days_q <= days_d;
      s2_tod_q  <= tod_d;
      s2_bad_q  <= s1_bad_q;
    end
  end

  // stage 3: days to seconds, wraps at 32 bits
  logic              s3_valid_q;
  logic [EpochW-1:0] s3_prod_q;
  logic [TodW-1:0]   s3_tod_q;
  logic              s3_bad_q;
  logic [32:0]       prod_full;

  assign prod_full = {17'd0, s2_days_q} * {16'd0, bte_pkg::SecPerDay};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_prod_q <= prod_full[EpochW-1:0];
      s3_tod_q  <= s2_tod_q;
      s3_bad_q  <= s2_bad_q;
    end
  end

  // stage 4: the day of month is one based, take one day off; modular sum
  logic              out_valid_q;
  logic [EpochW-1:0] out_epoch_q;
  logic              out_bad_q;
  logic [EpochW-1:0] epoch_d;

  assign epoch_d = s3_prod_q + EpochW'(s3_tod_q) - EpochW'(bte_pkg::SecPerDay);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      out_epoch_q <= s3_bad_q ? '0 : epoch_d;
      out_bad_q   <= s3_bad_q;
    end
  end

  assign done_o          = out_valid_q;
  assign epoch_seconds_o = out_epoch_q;
  assign month_invalid_o = out_bad_q;

  // a bad month always reports a zero timestamp
  a_bad_month_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!month_invalid_o || (epoch_seconds_o == '0)))
    else $error("bad month with nonzero timestamp");

  // every accepted beat comes out after passing through all four stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##3 done_o)
    else $error("accepted beat did not reach the output");

  // no result without a matching beat, and the flag follows that beat's month
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result beat without an accepted input");

  a_flag_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_invalid_o == $past(mon_bad, 4)))
    else $error("month flag does not match its input beat");

endmodule
